@@ rtl/cppr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cppr_pkg
// Shared constants, register indexes and inter-module types for the code
// point property range lookup.
// ----------------------------------------------------------------------------
package cppr_pkg;

   localparam int NUM_TABLES  = 6;
   localparam int TABLE_DEPTH = 256;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = IDX_W + 1;
   localparam int CP_W        = 21;
   localparam int ENTRY_W     = 2 * CP_W;
   localparam int USED_W      = 9;
   localparam int SEL_W       = 3;
   localparam int EIDX_W      = 8;
   localparam int CSR_IDX_W   = 3;
   localparam logic [CP_W-1:0] CP_MAX = 21'h10FFFF;

   // input modes
   localparam logic MODE_LOAD     = 1'b0;
   localparam logic MODE_CLASSIFY = 1'b1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_EMOJI_USED         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PRESENTATION_USED  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MODIFIER_USED      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MODIFIER_BASE_USED = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_COMPONENT_USED     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_PICTOGRAPHIC_USED  = 3'd5;

   typedef struct packed {
      logic              start;
      logic [USED_W-1:0] used;
      logic [CP_W-1:0]   cp;
      logic              wr_en;
      logic [IDX_W-1:0]  wr_addr;
      logic [CP_W-1:0]   wr_first;
      logic [CP_W-1:0]   wr_last;
   } search_ctrl_type;

   typedef struct packed {
      logic busy;
      logic hit;
   } search_stat_type;

endpackage

@@ rtl/cppr_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cppr_req_if
// Input item channel: load a range entry or classify a code point.
// ----------------------------------------------------------------------------
interface cppr_req_if;
   import cppr_pkg::*;

   logic                valid;
   logic                ready;
   logic                mode;
   logic [SEL_W-1:0]    table_select;
   logic [EIDX_W-1:0]   entry_index;
   logic [CP_W-1:0]     range_first;
   logic [CP_W-1:0]     range_last;
   logic [CP_W-1:0]     code_point;

   modport source (output valid, mode, table_select, entry_index, range_first,
                   range_last, code_point, input ready);
   modport sink (input valid, mode, table_select, entry_index, range_first,
                 range_last, code_point, output ready);
endinterface

@@ rtl/cppr_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cppr_rsp_if
// Result channel: property flag word per item.
// ----------------------------------------------------------------------------
interface cppr_rsp_if;
   import cppr_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [NUM_TABLES-1:0] property_flags;
   logic                  was_classify;

   modport source (output valid, property_flags, was_classify, input ready);
   modport sink (input valid, property_flags, was_classify, output ready);
endinterface

@@ rtl/cppr_csr_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cppr_csr_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface cppr_csr_if;
   import cppr_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [USED_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/cppr_table_search.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cppr_table_search
// One range table in a synchronous memory plus a binary search engine that
// issues one probe per cycle while a search is in progress.
// ----------------------------------------------------------------------------
module cppr_table_search (
   input  logic                      clock,
   input  logic                      reset,
   input  cppr_pkg::search_ctrl_type ctrl,
   output cppr_pkg::search_stat_type stat
);
   import cppr_pkg::*;

   logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic [CNT_W-1:0] mid_ff, mid_in;
   logic [CP_W-1:0]  cp_ff, cp_in;
   logic             busy_ff, busy_in;
   logic             hit_ff, hit_in;

   logic [CNT_W-1:0] start_hi;
   logic [CP_W-1:0]  probe_first;
   logic [CP_W-1:0]  probe_last;

   assign probe_first = rd_data_ff[ENTRY_W-1:CP_W];
   assign probe_last  = rd_data_ff[CP_W-1:0];

   // used length above the depth searches the whole table
   assign start_hi = (32'(ctrl.used) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                    : CNT_W'(ctrl.used);

   always_comb begin
      lo_in   = lo_ff;
      hi_in   = hi_ff;
      cp_in   = cp_ff;
      busy_in = busy_ff;
      hit_in  = hit_ff;
      if (ctrl.start) begin
         lo_in   = '0;
         hi_in   = start_hi;
         cp_in   = ctrl.cp;
         hit_in  = 1'b0;
         busy_in = (start_hi != '0);
      end else if (busy_ff) begin
         if (cp_ff >= probe_first) begin
            if (cp_ff <= probe_last) begin
               hit_in = 1'b1;
            end else begin
               lo_in = mid_ff + CNT_W'(1);
            end
         end else begin
            hi_in = mid_ff;
         end
         busy_in = !hit_in && (lo_in < hi_in);
      end
      // next probe address straight from this probe's outcome
      mid_in = lo_in + ((hi_in - lo_in) >> 1);
   end

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[ctrl.wr_addr] <= {ctrl.wr_first, ctrl.wr_last};
      end
      rd_data_ff <= mem[mid_in[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         hit_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         hit_ff  <= hit_in;
      end
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      mid_ff <= mid_in;
      cp_ff  <= cp_in;
   end

   assign stat.busy = busy_ff;
   assign stat.hit  = hit_ff;

endmodule

@@ rtl/code_point_property_range_lookup.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// code_point_property_range_lookup
// Classifies a code point against six loaded emoji property range tables.
// ----------------------------------------------------------------------------
// Six range tables of 256 entries each sit in six one-port-read memories and
// are searched side by side. A load transfer writes one range and passes
// through ST_FINISH, which fills the output register with a zero flag word.
// A classify transfer starts all six binary searches at once; each memory
// probe is a registered read, and the next address is formed from the
// returned entry. The sequencer waits in ST_SEARCH until every search is
// done and fills the output register in ST_FINISH; the next item is then
// taken in ST_IDLE. One item is worked on at a time; the result sits in an
// output register so the next item can be taken while the previous result
// waits. Memories have no reset: a search must only probe entries that
// were loaded. The user must write used lengths through the csr channel
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module code_point_property_range_lookup (
   input logic     clock,
   input logic     reset,
   cppr_req_if.sink   req_ch,
   cppr_rsp_if.source rsp_ch,
   cppr_csr_if.sink   csr_ch
);
   import cppr_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   logic [USED_W-1:0]     used_ff [NUM_TABLES];
   logic [NUM_TABLES-1:0] res_flags_ff, res_flags_in;
   logic                  res_classify_ff, res_classify_in;
   logic                  in_range_ff, in_range_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [NUM_TABLES-1:0] rsp_flags_ff, rsp_flags_in;
   logic                  rsp_classify_ff, rsp_classify_in;

   search_ctrl_type       ctrl [NUM_TABLES];
   search_stat_type       stat [NUM_TABLES];
   logic [NUM_TABLES-1:0] busy_vec;
   logic [NUM_TABLES-1:0] hit_vec;

   logic req_xfer;
   logic load_ok;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   // entry index beyond the table depth drops the load
   assign load_ok = (32'(req_ch.entry_index) < TABLE_DEPTH);

   // one search engine and memory per property table
   for (genvar t = 0; t < NUM_TABLES; t++) begin : g_table
      always_comb begin
         ctrl[t].start    = req_xfer && (req_ch.mode == MODE_CLASSIFY);
         ctrl[t].used     = used_ff[t];
         ctrl[t].cp       = req_ch.code_point;
         ctrl[t].wr_en    = req_xfer && (req_ch.mode == MODE_LOAD) && load_ok
                            && (req_ch.table_select == SEL_W'(t));
         ctrl[t].wr_addr  = IDX_W'(req_ch.entry_index);
         ctrl[t].wr_first = req_ch.range_first;
         ctrl[t].wr_last  = req_ch.range_last;
      end

      cppr_table_search u_search (
         .clock (clock),
         .reset (reset),
         .ctrl  (ctrl[t]),
         .stat  (stat[t])
      );

      assign busy_vec[t] = stat[t].busy;
      assign hit_vec[t]  = stat[t].hit;
   end

   // sequencer and output register
   always_comb begin
      state_in        = state_ff;
      res_flags_in    = res_flags_ff;
      res_classify_in = res_classify_ff;
      in_range_in     = in_range_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_flags_in    = rsp_flags_ff;
      rsp_classify_in = rsp_classify_ff;

      // output register drains on a transfer
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               res_classify_in = req_ch.mode;
               res_flags_in    = '0;
               // code points past the last plane match nothing
               in_range_in     = (req_ch.code_point <= CP_MAX);
               state_in = (req_ch.mode == MODE_CLASSIFY) ? ST_SEARCH : ST_FINISH;
            end
         end
         ST_SEARCH: begin
            if (busy_vec == '0) begin
               res_flags_in = in_range_ff ? hit_vec : '0;
               state_in     = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_in) begin
               rsp_valid_in    = 1'b1;
               rsp_flags_in    = res_flags_ff;
               rsp_classify_in = res_classify_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      res_flags_ff    <= res_flags_in;
      res_classify_ff <= res_classify_in;
      in_range_ff     <= in_range_in;
      rsp_flags_ff    <= rsp_flags_in;
      rsp_classify_ff <= rsp_classify_in;
   end

   // used-length registers, unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TABLES; i++) begin
            used_ff[i] <= '0;
         end
      end else if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            REG_EMOJI_USED:         used_ff[0] <= csr_ch.data;
            REG_PRESENTATION_USED:  used_ff[1] <= csr_ch.data;
            REG_MODIFIER_USED:      used_ff[2] <= csr_ch.data;
            REG_MODIFIER_BASE_USED: used_ff[3] <= csr_ch.data;
            REG_COMPONENT_USED:     used_ff[4] <= csr_ch.data;
            REG_PICTOGRAPHIC_USED:  used_ff[5] <= csr_ch.data;
            default: ;
         endcase
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.property_flags = rsp_flags_ff;
   assign rsp_ch.was_classify   = rsp_classify_ff;

endmodule

@@ dv/code_point_property_range_lookup_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// code_point_property_range_lookup_tb
// Self-checking bench for the emoji property range lookup. Range tables are
// loaded through the request channel and used lengths set through the csr
// channel. Each classify is predicted by a local binary search over a shadow
// copy of the six tables, each load expects a zero flag word, and every
// result is compared in order. Used lengths always stay within the loaded
// prefix of each table, so no search reads an entry that was never loaded.
// ----------------------------------------------------------------------------
module code_point_property_range_lookup_tb;
   import cppr_pkg::*;

   // table selects, numbered as the flag bits; the two top codes select nothing
   localparam logic [SEL_W-1:0] SEL_EMOJI         = 3'd0;
   localparam logic [SEL_W-1:0] SEL_PRESENTATION  = 3'd1;
   localparam logic [SEL_W-1:0] SEL_MODIFIER      = 3'd2;
   localparam logic [SEL_W-1:0] SEL_MODIFIER_BASE = 3'd3;
   localparam logic [SEL_W-1:0] SEL_COMPONENT     = 3'd4;
   localparam logic [SEL_W-1:0] SEL_PICTOGRAPHIC  = 3'd5;
   localparam logic [SEL_W-1:0] SEL_NONE_LOW      = 3'd6;
   localparam logic [SEL_W-1:0] SEL_NONE_HIGH     = 3'd7;

   localparam logic [CP_W-1:0] CP_ALL_ONES  = 21'h1FFFFF;
   localparam logic [USED_W-1:0] USED_OVER  = 9'h1FF;
   localparam int IDLE_SETTLE_CYCLES = 16;
   localparam int REPORT_LIMIT       = 10;

   typedef struct packed {
      logic              mode;
      logic [SEL_W-1:0]  table_select;
      logic [EIDX_W-1:0] entry_index;
      logic [CP_W-1:0]   range_first;
      logic [CP_W-1:0]   range_last;
      logic [CP_W-1:0]   code_point;
   } lookup_req_type;

   typedef struct packed {
      logic [NUM_TABLES-1:0] flags;
      logic                  was_classify;
   } flag_word_type;

   logic clock = 1'b0;
   logic reset;

   cppr_req_if req_ch ();
   cppr_rsp_if rsp_ch ();
   cppr_csr_if csr_ch ();

   code_point_property_range_lookup dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the tables and the used-length registers
   logic [CP_W-1:0]   span_first   [NUM_TABLES][TABLE_DEPTH];
   logic [CP_W-1:0]   span_last    [NUM_TABLES][TABLE_DEPTH];
   bit                entry_loaded [NUM_TABLES][TABLE_DEPTH];
   logic [USED_W-1:0] ranges_used  [NUM_TABLES];
   logic [USED_W-1:0] next_used    [NUM_TABLES];

   // flag words still owed by the block, oldest first
   flag_word_type flag_words_due [$];
   int unsigned mismatch_count = 0;
   int unsigned burst_left = 0;

   // ------------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------------

   // same probe order as the hardware search, so unsorted tables agree too
   function automatic logic [NUM_TABLES-1:0] predict_flags(input logic [CP_W-1:0] cp);
      logic [NUM_TABLES-1:0] flags;
      int lo;
      int hi;
      int mid;
      flags = '0;
      if (cp > CP_MAX) return flags;
      for (int t = 0; t < NUM_TABLES; t++) begin
         lo = 0;
         hi = (ranges_used[t] > TABLE_DEPTH) ? TABLE_DEPTH : int'(ranges_used[t]);
         while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (cp >= span_first[t][mid]) begin
               if (cp <= span_last[t][mid]) begin
                  flags[t] = 1'b1;
                  break;
               end
               lo = mid + 1;
            end else begin
               hi = mid;
            end
         end
      end
      return flags;
   endfunction

   // accepted transfer: update the shadow tables and queue the flag word
   function automatic void apply_item(input lookup_req_type item);
      flag_word_type due;
      due.flags = '0;
      due.was_classify = item.mode;
      if (item.mode == MODE_LOAD) begin
         if (item.table_select < NUM_TABLES) begin
            span_first[item.table_select][item.entry_index] = item.range_first;
            span_last[item.table_select][item.entry_index]  = item.range_last;
            entry_loaded[item.table_select][item.entry_index] = 1'b1;
         end
      end else begin
         due.flags = predict_flags(item.code_point);
      end
      flag_words_due.push_back(due);
   endfunction

   // number of entries loaded from index 0 upward without a hole
   function automatic int loaded_prefix(input int t);
      int n;
      n = 0;
      while (n < TABLE_DEPTH && entry_loaded[t][n]) n++;
      return n;
   endfunction

   function automatic int effective_used(input int t);
      return (ranges_used[t] > TABLE_DEPTH) ? TABLE_DEPTH : int'(ranges_used[t]);
   endfunction

   function automatic logic [CSR_IDX_W-1:0] used_reg_index(input int t);
      case (t)
         0:       return REG_EMOJI_USED;
         1:       return REG_PRESENTATION_USED;
         2:       return REG_MODIFIER_USED;
         3:       return REG_MODIFIER_BASE_USED;
         4:       return REG_COMPONENT_USED;
         default: return REG_PICTOGRAPHIC_USED;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // item builders: fields a mode ignores still carry random bits
   // ------------------------------------------------------------------------

   function automatic lookup_req_type make_load(input logic [SEL_W-1:0] sel,
                                                input logic [EIDX_W-1:0] idx,
                                                input logic [CP_W-1:0] first,
                                                input logic [CP_W-1:0] last);
      lookup_req_type item;
      item.mode         = MODE_LOAD;
      item.table_select = sel;
      item.entry_index  = idx;
      item.range_first  = first;
      item.range_last   = last;
      item.code_point   = CP_W'($urandom_range(0, CP_ALL_ONES));
      return item;
   endfunction

   function automatic lookup_req_type make_classify(input logic [CP_W-1:0] cp);
      lookup_req_type item;
      item.mode         = MODE_CLASSIFY;
      item.table_select = SEL_W'($urandom_range(0, 7));
      item.entry_index  = EIDX_W'($urandom_range(0, 255));
      item.range_first  = CP_W'($urandom_range(0, CP_ALL_ONES));
      item.range_last   = CP_W'($urandom_range(0, CP_ALL_ONES));
      item.code_point   = cp;
      return item;
   endfunction

   // mostly probes at and around range edges of searched entries
   function automatic logic [CP_W-1:0] pick_code_point();
      int t;
      int e;
      logic [CP_W-1:0] f;
      logic [CP_W-1:0] l;
      case ($urandom_range(0, 9))
         0: return CP_W'($urandom_range(0, CP_ALL_ONES));
         1: return CP_W'($urandom_range(CP_MAX + 1, CP_ALL_ONES));
         2: return CP_W'($urandom_range(0, CP_MAX));
         default: begin
            t = $urandom_range(0, NUM_TABLES - 1);
            if (effective_used(t) == 0) return CP_W'($urandom_range(0, CP_MAX));
            e = $urandom_range(0, effective_used(t) - 1);
            f = span_first[t][e];
            l = span_last[t][e];
            case ($urandom_range(0, 4))
               0: return f;
               1: return l;
               2: return f - 1'b1;
               3: return l + 1'b1;
               default: return (f <= l) ? CP_W'($urandom_range(f, l)) : f;
            endcase
         end
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // channel drivers
   // ------------------------------------------------------------------------

   // bursts of back-to-back transfers with random gaps in between
   task automatic send_item(input lookup_req_type item);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      req_ch.valid        <= 1'b1;
      req_ch.mode         <= item.mode;
      req_ch.table_select <= item.table_select;
      req_ch.entry_index  <= item.entry_index;
      req_ch.range_first  <= item.range_first;
      req_ch.range_last   <= item.range_last;
      req_ch.code_point   <= item.code_point;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      burst_left--;
      apply_item(item);
   endtask

   // block is idle once every flag word is back and the pipe has drained
   task automatic wait_block_idle();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      while (flag_words_due.size() != 0) @(posedge clock);
      repeat (IDLE_SETTLE_CYCLES) @(posedge clock);
   endtask

   // writes all six used lengths from next_used in one run of transfers
   task automatic program_used_lengths();
      for (int t = 0; t < NUM_TABLES; t++) begin
         csr_ch.valid <= 1'b1;
         csr_ch.index <= used_reg_index(t);
         csr_ch.data  <= next_used[t];
         @(posedge clock);
         while (!csr_ch.ready) @(posedge clock);
         ranges_used[t] = next_used[t];
      end
      csr_ch.valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // result side: stall pattern and in-order check
   // ------------------------------------------------------------------------

   int unsigned stall_phase_left = 0;
   int unsigned stall_run = 0;
   int unsigned stall_style = 0;
   bit          stall_hold = 1'b0;

   // styles: always ready, coin flip, mostly ready, long alternating runs
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (stall_phase_left == 0) begin
            stall_style = $urandom_range(0, 3);
            stall_phase_left = $urandom_range(50, 300);
         end
         stall_phase_left--;
         case (stall_style)
            0: begin
               rsp_ch.ready <= 1'b1;
            end
            1: begin
               rsp_ch.ready <= 1'($urandom_range(0, 1));
            end
            2: begin
               rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
               if (stall_run == 0) begin
                  stall_run = $urandom_range(1, 20);
                  stall_hold = !stall_hold;
               end
               stall_run--;
               rsp_ch.ready <= !stall_hold;
            end
         endcase
      end
   end

   function automatic void note_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) $display("%0t ns: %s", $time, msg);
   endfunction

   always @(posedge clock) begin : result_check
      flag_word_type due;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (flag_words_due.size() == 0) begin
            note_failure($sformatf("result transfer with nothing owed: flags=%h was_classify=%b",
                                   rsp_ch.property_flags, rsp_ch.was_classify));
         end else begin
            due = flag_words_due.pop_front();
            if (rsp_ch.property_flags !== due.flags)
               note_failure($sformatf("property_flags: expected %h, got %h",
                                      due.flags, rsp_ch.property_flags));
            if (rsp_ch.was_classify !== due.was_classify)
               note_failure($sformatf("was_classify: expected %b, got %b",
                                      due.was_classify, rsp_ch.was_classify));
         end
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // all used lengths are zero out of reset, so nothing can match
   task automatic test_empty_tables();
      send_item(make_classify(21'h01F600));
      send_item(make_classify(CP_MAX));
      wait_block_idle();
   endtask

   // hand-built tables hitting field extremes and the odd cases
   task automatic test_directed_lookups();
      send_item(make_load(SEL_EMOJI, 8'd0, 21'h000000, 21'h000000));
      send_item(make_load(SEL_EMOJI, 8'd1, 21'h01F600, 21'h01F64F));
      send_item(make_load(SEL_EMOJI, 8'd2, CP_MAX, CP_MAX));
      // top entry index, past the used length
      send_item(make_load(SEL_EMOJI, 8'd255, 21'h01F900, 21'h01F9FF));
      send_item(make_load(SEL_PRESENTATION, 8'd0, 21'h01F600, 21'h01F600));
      // middle entry has first above last: the search must step past it
      send_item(make_load(SEL_MODIFIER, 8'd0, 21'h01F3FB, 21'h01F3FC));
      send_item(make_load(SEL_MODIFIER, 8'd1, 21'h01F3FE, 21'h01F3FD));
      send_item(make_load(SEL_MODIFIER, 8'd2, 21'h01F3FE, 21'h01F3FF));
      send_item(make_load(SEL_MODIFIER_BASE, 8'd0, 21'h000020, 21'h00007E));
      send_item(make_load(SEL_COMPONENT, 8'd0, 21'h000030, 21'h000039));
      send_item(make_load(SEL_PICTOGRAPHIC, 8'd0, 21'h000000, CP_MAX));
      // selects with no table behind them: result only
      send_item(make_load(SEL_NONE_LOW, 8'd0, CP_MAX, 21'h000000));
      send_item(make_load(SEL_NONE_HIGH, 8'd255, CP_ALL_ONES, CP_ALL_ONES));
      wait_block_idle();

      next_used[0] = 9'd3;
      next_used[1] = 9'd1;
      next_used[2] = 9'd3;
      next_used[3] = 9'd1;
      next_used[4] = 9'd1;
      next_used[5] = 9'd1;
      program_used_lengths();

      send_item(make_classify(21'h000000));
      send_item(make_classify(21'h01F3FE));
      send_item(make_classify(21'h01F600));
      send_item(make_classify(21'h01F64F));
      send_item(make_classify(21'h01F650));
      send_item(make_classify(21'h000035));
      send_item(make_classify(CP_MAX));
      // just past the code space, and the top of the field
      send_item(make_classify(CP_MAX + 1'b1));
      send_item(make_classify(CP_ALL_ONES));
      wait_block_idle();
   endtask

   // emoji table loaded to full depth, searched at 256 and at an oversize length
   task automatic test_full_emoji_table();
      int order [TABLE_DEPTH];
      int k;
      int tmp;
      int i;
      logic [CP_W-1:0] f;
      logic [CP_W-1:0] l;
      for (int j = 0; j < TABLE_DEPTH; j++) order[j] = j;
      for (int j = TABLE_DEPTH - 1; j > 0; j--) begin
         k = $urandom_range(0, j);
         tmp = order[j];
         order[j] = order[k];
         order[k] = tmp;
      end
      // one slot of 4352 code points per entry keeps the table sorted
      for (int j = 0; j < TABLE_DEPTH; j++) begin
         i = order[j];
         f = CP_W'(i * 4352 + $urandom_range(0, 2000));
         l = CP_W'(f + $urandom_range(0, 2200));
         if (i == 0) f = '0;
         if (i == TABLE_DEPTH - 1) l = CP_MAX;
         send_item(make_load(SEL_EMOJI, i[EIDX_W-1:0], f, l));
      end
      wait_block_idle();

      for (int t = 0; t < NUM_TABLES; t++) next_used[t] = USED_W'(loaded_prefix(t));
      next_used[0] = USED_W'(TABLE_DEPTH);
      program_used_lengths();
      repeat (30) send_item(make_classify(pick_code_point()));
      wait_block_idle();

      // register above the depth searches the full depth
      next_used[0] = USED_OVER;
      program_used_lengths();
      repeat (30) send_item(make_classify(pick_code_point()));
      wait_block_idle();
   endtask

   // loads n entries of one table in shuffled order, some tables left broken
   task automatic load_random_table(input int t, input int n);
      logic [CP_W-1:0] lo_cp [64];
      logic [CP_W-1:0] hi_cp [64];
      int order [64];
      int unsigned step;
      int unsigned cursor;
      int k;
      int tmp;
      logic [CP_W-1:0] swap_cp;
      if (n == 0) return;
      // dense tables sit in the emoji block, sparse ones span the code space
      if ($urandom_range(0, 1) == 0) begin
         step = $urandom_range(1, 40);
         cursor = 21'h01F000 + $urandom_range(0, 255);
      end else begin
         step = (CP_MAX + 1) / (2 * n + 2);
         cursor = $urandom_range(0, step);
      end
      for (int i = 0; i < n; i++) begin
         lo_cp[i] = CP_W'(cursor + $urandom_range(0, step));
         hi_cp[i] = CP_W'(lo_cp[i] + $urandom_range(0, step));
         if (cursor + 2 * step > CP_MAX) begin
            lo_cp[i] = CP_MAX;
            hi_cp[i] = CP_MAX;
         end
         cursor = hi_cp[i] + 1;
         order[i] = i;
      end
      // broken tables: an inverted entry or one dropped anywhere
      if ($urandom_range(0, 4) == 0) begin
         k = $urandom_range(0, n - 1);
         if ($urandom_range(0, 1) == 0) begin
            swap_cp = lo_cp[k];
            lo_cp[k] = hi_cp[k];
            hi_cp[k] = swap_cp;
         end else begin
            lo_cp[k] = CP_W'($urandom_range(0, CP_MAX));
            hi_cp[k] = CP_W'($urandom_range(lo_cp[k], CP_MAX));
         end
      end
      for (int i = n - 1; i > 0; i--) begin
         k = $urandom_range(0, i);
         tmp = order[i];
         order[i] = order[k];
         order[k] = tmp;
      end
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) == 0)
            send_item(make_load(SEL_W'($urandom_range(SEL_NONE_LOW, SEL_NONE_HIGH)),
                                EIDX_W'($urandom_range(0, 255)),
                                CP_W'($urandom_range(0, CP_ALL_ONES)),
                                CP_W'($urandom_range(0, CP_ALL_ONES))));
         send_item(make_load(t[SEL_W-1:0], order[i][EIDX_W-1:0],
                             lo_cp[order[i]], hi_cp[order[i]]));
      end
   endtask

   // a round of fresh tables, new used lengths, then mixed traffic
   task automatic test_random_tables();
      int sizes [NUM_TABLES];
      int t;
      int p;
      logic [CP_W-1:0] f;
      for (int round = 0; round < 1; round++) begin
         for (int i = 0; i < NUM_TABLES; i++) begin
            sizes[i] = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                   : $urandom_range(0, 12);
            load_random_table(i, sizes[i]);
         end
         wait_block_idle();

         // any length up to the loaded prefix is safe to search
         for (int i = 0; i < NUM_TABLES; i++) begin
            p = loaded_prefix(i);
            next_used[i] = USED_W'(($urandom_range(0, 3) != 0) ? sizes[i]
                                                               : $urandom_range(0, p));
            if (p == TABLE_DEPTH && $urandom_range(0, 3) == 0) next_used[i] = USED_OVER;
         end
         program_used_lengths();

         for (int j = 0; j < 40; j++) begin
            if ($urandom_range(0, 11) == 0) begin
               // rewrite a loaded entry while its table is live
               t = $urandom_range(0, NUM_TABLES - 1);
               p = loaded_prefix(t);
               f = CP_W'($urandom_range(0, CP_MAX));
               send_item(make_load(t[SEL_W-1:0],
                                   (p == 0) ? 8'd0 : EIDX_W'($urandom_range(0, p - 1)),
                                   f, CP_W'($urandom_range(0, CP_MAX))));
            end
            send_item(make_classify(pick_code_point()));
         end
         wait_block_idle();
      end
   endtask

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------

   initial begin
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.mode         <= MODE_LOAD;
      req_ch.table_select <= '0;
      req_ch.entry_index  <= '0;
      req_ch.range_first  <= '0;
      req_ch.range_last   <= '0;
      req_ch.code_point   <= '0;
      csr_ch.valid        <= 1'b0;
      csr_ch.index        <= REG_EMOJI_USED;
      csr_ch.data         <= '0;
      for (int t = 0; t < NUM_TABLES; t++) begin
         ranges_used[t] = '0;
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            span_first[t][i] = '0;
            span_last[t][i] = '0;
            entry_loaded[t][i] = 1'b0;
         end
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_tables();
      test_directed_lookups();
      test_full_emoji_table();
      test_random_tables();

      wait_block_idle();
      if (mismatch_count == 0 && flag_words_due.size() == 0) begin
         $display("code_point_property_range_lookup: match");
      end else begin
         $display("code_point_property_range_lookup: mismatch");
      end
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("code_point_property_range_lookup: mismatch");
      $finish;
   end

endmodule
